// ===== rtl/core/fmpm_pkg.sv =====
// shared widths, opcode and status codes for the first-match position map
package fmpm_pkg;

  localparam int KEY_W      = 32;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 3;
  localparam int POS_OUT_W  = 20;

  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_POSITION_BITS = 20;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_BAD_SLOT = 3'd4,
    ST_POS_OVF  = 3'd5
  } status_t;

endpackage

// ===== rtl/core/fmpm_ram.sv =====
// generic single write port, single read port ram with registered read
module fmpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/first_match_position_map.sv =====
// first-match position map: key table with linear live-match scan and position recording
//
// A command word (clear, load, query or read) is taken when cmd_valid and cmd_ready
// are both high; each command gives exactly one result word on the res channel. The
// table sits in one ram holding key, live flag and recorded position per slot. Load
// and query scan the loaded slots in order through one shared key comparator, one
// slot per cycle, stopping at the first live match, so such a command ends sooner
// when it hits early. Clear, a load into a full table and a query at position overflow
// skip the scan and go straight to the result; a read first does one ram read. The
// block takes no new command while one is in work, but it does take the next command
// while a finished result still waits on res_ready. Slots at or beyond entry_count are
// never looked at, so clear only resets the two counters and no clearing pass runs
// after reset or clear.
module first_match_position_map #(
  parameter int TABLE_ENTRIES = fmpm_pkg::DEF_TABLE_ENTRIES,
  parameter int POSITION_BITS = fmpm_pkg::DEF_POSITION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [fmpm_pkg::OP_W-1:0]         opcode,
  input  logic signed [fmpm_pkg::KEY_W-1:0] key,
  input  logic [fmpm_pkg::SLOT_W-1:0]       slot,
  // result channel
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [fmpm_pkg::STATUS_W-1:0]     status,
  output logic [fmpm_pkg::SLOT_W-1:0]       hit_slot,
  output logic [fmpm_pkg::POS_OUT_W-1:0]    position
);

  import fmpm_pkg::*;

  // slot address and fill count widths
  localparam int ADDR_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = KEY_W + 1 + POSITION_BITS;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic                     live;
    logic [POSITION_BITS-1:0] pos;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EMIT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         entry_count;
  logic [POSITION_BITS-1:0] query_count;

  // command in work
  op_t                      cur_op;
  logic [KEY_W-1:0]         cur_key;

  // scan pointers: scan_idx is the next slot to read, chk_idx the slot now on rdata
  logic [CNT_W-1:0]         scan_idx;
  logic [ADDR_W-1:0]        chk_idx;
  logic                     chk_vld;

  // finished result waiting for the output register
  status_t                  rslt_status;
  logic [SLOT_W-1:0]        rslt_slot;
  logic [POS_OUT_W-1:0]     rslt_pos;

  // ram ports
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  entry_t                   ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  entry_t                   rd_entry;

  // shared comparator and scan control
  logic                     match;
  logic                     scan_done;
  logic                     issue;
  logic                     scan_end;
  logic                     out_free;
  logic                     full;
  logic                     pos_ovf;
  logic                     bad_slot;

  fmpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;

  // live-key compare on the slot just read
  assign match     = chk_vld && rd_entry.live && (rd_entry.key == cur_key);
  // all loaded slots read and compared without a hit
  assign scan_done = !chk_vld && (scan_idx == entry_count);
  assign issue     = (state == S_SCAN) && (scan_idx != entry_count);
  assign scan_end  = (state == S_SCAN) && (match || scan_done);

  assign full      = (entry_count == CNT_W'(TABLE_ENTRIES));
  assign pos_ovf   = (query_count == {POSITION_BITS{1'b1}});
  assign bad_slot  = (32'(slot) >= 32'(entry_count));

  // in idle the read port follows the slot field so a read command has its data next cycle
  assign ram_raddr = (state == S_IDLE) ? ADDR_W'(slot) : scan_idx[ADDR_W-1:0];

  // load writes its new slot at scan end, a query hit kills the matched entry
  always_comb begin
    ram_we          = scan_end && ((cur_op == OP_LOAD) || match);
    ram_wdata.key   = cur_key;
    if (cur_op == OP_LOAD) begin
      ram_waddr      = entry_count[ADDR_W-1:0];
      ram_wdata.live = !match;
      ram_wdata.pos  = '0;
    end else begin
      ram_waddr      = chk_idx;
      ram_wdata.live = 1'b0;
      ram_wdata.pos  = query_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      entry_count <= '0;
      query_count <= '0;
      chk_vld     <= 1'b0;
    end else begin
      // in S_EMIT the word is either held or replaced below
      if (res_valid && res_ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_op   <= op_t'(opcode);
            cur_key  <= key;
            scan_idx <= '0;
            chk_vld  <= 1'b0;
            unique case (op_t'(opcode))
              OP_CLEAR: begin
                entry_count <= '0;
                query_count <= '0;
                rslt_status <= ST_OK;
                rslt_slot   <= '0;
                rslt_pos    <= '0;
                state       <= S_EMIT;
              end
              OP_LOAD: begin
                if (full) begin
                  rslt_status <= ST_FULL;
                  rslt_slot   <= '0;
                  rslt_pos    <= '0;
                  state       <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_QUERY: begin
                if (pos_ovf) begin
                  rslt_status <= ST_POS_OVF;
                  rslt_slot   <= '0;
                  rslt_pos    <= '0;
                  state       <= S_EMIT;
                end else begin
                  // position is taken whether or not the query hits
                  query_count <= query_count + POSITION_BITS'(1);
                  state       <= S_SCAN;
                end
              end
              OP_READ: begin
                if (bad_slot) begin
                  rslt_status <= ST_BAD_SLOT;
                  rslt_slot   <= '0;
                  rslt_pos    <= '0;
                  state       <= S_EMIT;
                end else begin
                  rslt_slot <= slot;
                  state     <= S_READ;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          chk_vld <= issue && !scan_end;
          chk_idx <= scan_idx[ADDR_W-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (scan_end) begin
            state   <= S_EMIT;
            if (cur_op == OP_LOAD) begin
              // a duplicate is stored and counted but stays dead
              entry_count <= entry_count + CNT_W'(1);
              rslt_status <= match ? ST_DUP : ST_OK;
              rslt_slot   <= SLOT_W'(entry_count);
              rslt_pos    <= '0;
            end else if (match) begin
              rslt_status <= ST_OK;
              rslt_slot   <= SLOT_W'(chk_idx);
              rslt_pos    <= POS_OUT_W'(query_count);
            end else begin
              rslt_status <= ST_NO_MATCH;
              rslt_slot   <= '0;
              rslt_pos    <= '0;
            end
          end
        end
        S_READ: begin
          rslt_status <= ST_OK;
          rslt_pos    <= POS_OUT_W'(rd_entry.pos);
          state       <= S_EMIT;
        end
        S_EMIT: begin
          // hand the result to the output register once it is free
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= rslt_status;
            hit_slot  <= rslt_slot;
            position  <= rslt_pos;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/fmpm_checker.sv =====
// port-level checker for the first-match position map, with its bind
module fmpm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic [fmpm_pkg::OP_W-1:0]         opcode,
  input logic signed [fmpm_pkg::KEY_W-1:0] key,
  input logic [fmpm_pkg::SLOT_W-1:0]       slot,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [fmpm_pkg::STATUS_W-1:0]     status,
  input logic [fmpm_pkg::SLOT_W-1:0]       hit_slot,
  input logic [fmpm_pkg::POS_OUT_W-1:0]    position
);

  import fmpm_pkg::*;

  // a result word that is not taken holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(hit_slot)
      && $stable(position))
    else $error("result word changed while stalled");

  // one command in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in work");

  // error results carry no slot and no position
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_FULL || status == ST_NO_MATCH || status == ST_BAD_SLOT
      || status == ST_POS_OVF) |-> hit_slot == '0 && position == '0)
    else $error("error result with nonzero slot or position");

  // a duplicate load result never reports a position
  a_dup_no_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_DUP |-> position == '0)
    else $error("duplicate load result with a position");

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind first_match_position_map fmpm_checker u_fmpm_checker (.*);
